>>> hw/rtl/jsu_pkg.sv
// Shared types, character codes and UTF-8 encode helpers for the JSON string unescaper.
// No dependencies; imported by jsu_decode and json_string_unescape_utf8_top.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  localparam int unsigned MAX_BURST = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } esc_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } utf_t;

  // Up to four output bytes caused by one input beat
  typedef struct packed {
    logic [2:0]                n;
    logic [MAX_BURST-1:0][7:0] bytes;
  } jsu_burst_t;

  typedef enum logic [2:0] {
    MODE_TEXT    = 3'd0,
    MODE_ESC     = 3'd1,
    MODE_HEX     = 3'd2,
    MODE_HI_WAIT = 3'd3,
    MODE_HI_ESC  = 3'd4,
    MODE_LO_HEX  = 3'd5
  } scan_mode_t;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_0         = 8'h30;
  localparam logic [7:0] CH_9         = 8'h39;
  localparam logic [7:0] CH_LA        = 8'h61;
  localparam logic [7:0] CH_LF        = 8'h66;
  localparam logic [7:0] CH_UA        = 8'h41;
  localparam logic [7:0] CH_UF        = 8'h46;

  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_HT = 8'h09;
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_BS = 8'h08;
  localparam logic [7:0] BYTE_FF = 8'h0C;

  localparam logic [5:0] HI_SURR_TAG = 6'b110110;
  localparam logic [5:0] LO_SURR_TAG = 6'b110111;

  localparam logic [20:0] SUPP_BASE = 21'h010000;
  localparam logic [20:0] CP_LIMIT  = 21'h110000;

  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] CONT  = 8'h80;

  function automatic logic [7:0] escape_map(input logic [7:0] ch);
    logic [7:0] r;
    r = ch;
    if (ch == CH_N) r = BYTE_LF;
    else if (ch == CH_T) r = BYTE_HT;
    else if (ch == CH_R) r = BYTE_CR;
    else if (ch == CH_B) r = BYTE_BS;
    else if (ch == CH_F) r = BYTE_FF;
    return r;
  endfunction

  function automatic jsu_burst_t single_byte(input logic [7:0] b);
    jsu_burst_t r;
    r          = '0;
    r.n        = 3'd1;
    r.bytes[0] = b;
    return r;
  endfunction

  function automatic jsu_burst_t encode_utf8(input logic [20:0] cp);
    jsu_burst_t r;
    r = '0;
    priority if (cp == '0) begin
      r.n = 3'd0;
    end else if (cp < 21'h80) begin
      r.n        = 3'd1;
      r.bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      r.n        = 3'd2;
      r.bytes[0] = LEAD2 | {3'b0, cp[10:6]};
      r.bytes[1] = CONT | {2'b0, cp[5:0]};
    end else if (cp < SUPP_BASE) begin
      r.n        = 3'd3;
      r.bytes[0] = LEAD3 | {4'b0, cp[15:12]};
      r.bytes[1] = CONT | {2'b0, cp[11:6]};
      r.bytes[2] = CONT | {2'b0, cp[5:0]};
    end else if (cp < CP_LIMIT) begin
      r.n        = 3'd4;
      r.bytes[0] = LEAD4 | {5'b0, cp[20:18]};
      r.bytes[1] = CONT | {2'b0, cp[17:12]};
      r.bytes[2] = CONT | {2'b0, cp[11:6]};
      r.bytes[3] = CONT | {2'b0, cp[5:0]};
    end else begin
      r.n = 3'd0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/jsu_decode.sv
// Escape scanner: holds the scan state and turns one escaped byte into 0 to 4 UTF-8 bytes.
// Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_decode import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  esc_t       item,
  output jsu_burst_t burst
);

  scan_mode_t  mode, mode_next;
  logic [1:0]  digit_count, digit_count_next;
  logic [15:0] hex_value, hex_value_next;
  logic        hex_stopped, hex_stopped_next;
  logic [9:0]  hi_bits, hi_bits_next;

  logic [7:0]  ch;
  logic        is_dec, is_lower, is_upper, is_hex;
  logic [3:0]  digit;
  logic [15:0] dig_hex;
  logic        dig_stop;
  logic        dig_done;
  logic [20:0] pair_cp;

  assign ch       = item.in_byte;
  assign is_dec   = (ch >= CH_0) && (ch <= CH_9);
  assign is_lower = (ch >= CH_LA) && (ch <= CH_LF);
  assign is_upper = (ch >= CH_UA) && (ch <= CH_UF);
  assign is_hex   = is_dec || is_lower || is_upper;
  assign digit    = is_dec ? ch[3:0] : (ch[3:0] + 4'd9);

  // Once a non-hex byte shows up, later digits of the four add nothing
  assign dig_hex  = (hex_stopped || !is_hex) ? hex_value : {hex_value[11:0], digit};
  assign dig_stop = hex_stopped || !is_hex;
  assign dig_done = (digit_count == 2'd3);
  assign pair_cp  = 21'({hi_bits, dig_hex[9:0]}) + SUPP_BASE;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_TEXT;
      digit_count <= '0;
      hex_value   <= '0;
      hex_stopped <= 1'b0;
      hi_bits     <= '0;
    end else if (take) begin
      mode        <= mode_next;
      digit_count <= digit_count_next;
      hex_value   <= hex_value_next;
      hex_stopped <= hex_stopped_next;
      hi_bits     <= hi_bits_next;
    end
  end

  always_comb begin
    mode_next        = mode;
    digit_count_next = digit_count;
    hex_value_next   = hex_value;
    hex_stopped_next = hex_stopped;
    hi_bits_next     = hi_bits;
    burst            = '0;
    unique case (mode)
      MODE_ESC, MODE_HI_ESC: begin
        if (ch == CH_U) begin
          digit_count_next = '0;
          hex_value_next   = '0;
          hex_stopped_next = 1'b0;
          mode_next        = (mode == MODE_ESC) ? MODE_HEX : MODE_LO_HEX;
        end else begin
          burst     = single_byte(escape_map(ch));
          mode_next = MODE_TEXT;
        end
      end
      MODE_HEX: begin
        hex_value_next   = dig_hex;
        hex_stopped_next = dig_stop;
        digit_count_next = digit_count + 2'd1;
        if (dig_done) begin
          if (dig_hex[15:10] == HI_SURR_TAG) begin
            hi_bits_next = dig_hex[9:0];
            mode_next    = MODE_HI_WAIT;
          end else begin
            burst     = encode_utf8(21'(dig_hex));
            mode_next = MODE_TEXT;
          end
        end
      end
      MODE_HI_WAIT: begin
        // Anything but a backslash drops the pending high surrogate
        if (ch == CH_BACKSLASH) begin
          mode_next = MODE_HI_ESC;
        end else begin
          burst     = single_byte(ch);
          mode_next = MODE_TEXT;
        end
      end
      MODE_LO_HEX: begin
        hex_value_next   = dig_hex;
        hex_stopped_next = dig_stop;
        digit_count_next = digit_count + 2'd1;
        if (dig_done) begin
          if (dig_hex[15:10] == LO_SURR_TAG) begin
            burst = encode_utf8(pair_cp);
          end else begin
            burst = encode_utf8(21'(dig_hex));
          end
          mode_next = MODE_TEXT;
        end
      end
      default: begin
        if (ch == CH_BACKSLASH) begin
          mode_next = MODE_ESC;
        end else begin
          burst     = single_byte(ch);
          mode_next = MODE_TEXT;
        end
      end
    endcase
    if (item.end_of_string) begin
      mode_next        = MODE_TEXT;
      digit_count_next = '0;
      hex_value_next   = '0;
      hex_stopped_next = 1'b0;
    end
  end

`ifndef SYNTH
  a_partial_digits_silent: assert property (@(posedge clk) disable iff (rst)
    (take && (mode == MODE_HEX || mode == MODE_LO_HEX) && digit_count != 2'd3)
      |-> burst.n == 3'd0)
    else $error("partial hex digit produced output");

  a_eos_returns_text: assert property (@(posedge clk) disable iff (rst)
    (take && item.end_of_string) |=> (mode == MODE_TEXT && digit_count == 2'd0))
    else $error("end of string did not restore text mode");

  a_escape_start_silent: assert property (@(posedge clk) disable iff (rst)
    (take && (mode == MODE_TEXT || mode == MODE_HI_WAIT) && ch == CH_BACKSLASH)
      |-> burst.n == 3'd0)
    else $error("backslash produced output");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/json_string_unescape_utf8_top.sv
// JSON string unescaper to UTF-8: top level with the output byte queue.
// Depends on jsu_pkg and jsu_decode.
//
// Usage:
//   esc channel (esc_valid/esc_ready/esc_data) takes one escaped string-body byte a beat,
//   with end_of_string set on the last byte of a string.
//   utf channel (utf_valid/utf_ready/utf_data) delivers unescaped UTF-8 bytes one a beat;
//   run_last marks the last byte caused by a given input beat.
// Timing:
//   An input beat is decoded in the cycle it is accepted and its 0 to 4 bytes are written
//   into a FIFO_DEPTH-entry byte queue, whose oldest byte is offered on utf.
//   The esc side takes one beat per cycle while esc_ready is high; the queue drains one
//   byte per cycle while utf_ready is high. esc_ready drops while the queue holds more
//   than FIFO_DEPTH - 4 bytes; it returns as bytes are taken.
// Reset (rst, synchronous, active high): the queue empties, the scanner returns to plain
//   text and any pending escape or high surrogate is lost.
// FIFO_DEPTH: power of two, 8 or more.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8_top import jsu_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic esc_valid,
  output logic esc_ready,
  input  esc_t esc_data,
  output logic utf_valid,
  input  logic utf_ready,
  output utf_t utf_data
);

  localparam int unsigned AW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = AW + 1;

  logic [CW-1:0] count;
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  utf_t          mem [FIFO_DEPTH];

  jsu_burst_t burst;
  logic       take;
  logic       pop;
  logic [2:0] push_n;

  jsu_decode u_decode (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .item  (esc_data),
    .burst (burst)
  );

  assign take      = esc_valid && esc_ready;
  assign pop       = utf_valid && utf_ready;
  assign push_n    = take ? burst.n : 3'd0;
  assign esc_ready = (count <= CW'(FIFO_DEPTH - MAX_BURST));
  assign utf_valid = (count != '0);
  assign utf_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      count  <= count + CW'(push_n) - CW'(pop);
      wr_ptr <= wr_ptr + AW'(push_n);
      rd_ptr <= rd_ptr + AW'(pop);
    end
  end

  // Write the beat's bytes into consecutive slots; flag the final one
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_BURST; i++) begin
      if (take && (3'(i) < burst.n)) begin
        mem[wr_ptr + AW'(i)] <= '{out_byte: burst.bytes[i], run_last: (3'(i + 1) == burst.n)};
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(FIFO_DEPTH))
    else $error("byte queue count beyond depth");

  a_room_on_take: assert property (@(posedge clk) disable iff (rst)
    take |-> ((CW + 1)'(count) + (CW + 1)'(burst.n)) <= (CW + 1)'(FIFO_DEPTH))
    else $error("input beat accepted without room for its bytes");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    (take && !pop) |=> count == $past(count) + CW'($past(push_n)))
    else $error("byte queue count out of step with writes");
`endif

endmodule

`default_nettype wire
